/* rtl/sste_pkg.sv */
// Shared types and codes for the small set table engine.
package sste_pkg;

   localparam int DATA_W   = 32;
   localparam int KIND_W   = 3;
   localparam int STATUS_W = 3;
   localparam int CNT_W    = 4;

   // command kinds
   localparam logic [KIND_W-1:0] KIND_APPEND_A = 3'd0;
   localparam logic [KIND_W-1:0] KIND_APPEND_B = 3'd1;
   localparam logic [KIND_W-1:0] KIND_SEARCH   = 3'd2;
   localparam logic [KIND_W-1:0] KIND_REMOVE   = 3'd3;
   localparam logic [KIND_W-1:0] KIND_ISECT    = 3'd4;
   localparam logic [KIND_W-1:0] KIND_UNION    = 3'd5;

   // result status codes
   localparam logic [STATUS_W-1:0] STAT_APPENDED    = 3'd0;
   localparam logic [STATUS_W-1:0] STAT_FULL        = 3'd1;
   localparam logic [STATUS_W-1:0] STAT_FOUND       = 3'd2;
   localparam logic [STATUS_W-1:0] STAT_ABSENT      = 3'd3;
   localparam logic [STATUS_W-1:0] STAT_REMOVED     = 3'd4;
   localparam logic [STATUS_W-1:0] STAT_NOT_REMOVED = 3'd5;
   localparam logic [STATUS_W-1:0] STAT_ELEMENT     = 3'd6;
   localparam logic [STATUS_W-1:0] STAT_EMPTY       = 3'd7;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_REMOVE,
      ST_SHIFT,
      ST_ISECT,
      ST_UNION
   } state_type;

   // sequencer to datapath: storage writes, read indexes, compare operand select
   typedef struct packed {
      logic                     a_wr_en;
      logic [CNT_W-1:0]         a_wr_idx;
      logic signed [DATA_W-1:0] a_wr_data;
      logic                     b_wr_en;
      logic [CNT_W-1:0]         b_wr_idx;
      logic signed [DATA_W-1:0] b_wr_data;
      logic [CNT_W-1:0]         a_rd_idx;
      logic [CNT_W-1:0]         b_rd_idx;
      logic                     cmp_use_value;
      logic signed [DATA_W-1:0] cmp_value;
   } ctl_type;

   // datapath to sequencer: read data and compare flags
   typedef struct packed {
      logic signed [DATA_W-1:0] a_rd_data;
      logic signed [DATA_W-1:0] b_rd_data;
      logic                     eq;
      logic                     gt;
   } stat_type;

endpackage

/* rtl/sste_cmp.sv */
// Shared compare unit: equality and signed greater-than.
module sste_cmp (
   input  logic signed [sste_pkg::DATA_W-1:0] lhs,
   input  logic signed [sste_pkg::DATA_W-1:0] rhs,
   output logic                               eq,
   output logic                               gt
);

   // one equality and one signed magnitude compare, shared by search, remove, intersection and union
   always_comb begin
      eq = (lhs == rhs);
      gt = (lhs > rhs);
   end

endmodule

/* rtl/sste_ctrl.sv */
// Sequencer: command decode, index counters, set counts and result register.
module sste_ctrl #(
   parameter int SET_CAPACITY = 8
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic [sste_pkg::KIND_W-1:0]        req_kind,
   input  logic signed [sste_pkg::DATA_W-1:0] req_value,
   input  sste_pkg::stat_type                 stat,
   output sste_pkg::ctl_type                  ctl,
   output logic                               rsp_strobe,
   output logic [sste_pkg::STATUS_W-1:0]      rsp_status,
   output logic signed [sste_pkg::DATA_W-1:0] rsp_element,
   output logic                               rsp_last
);

   localparam int CNT_W = sste_pkg::CNT_W;
   localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(SET_CAPACITY);
   localparam logic [CNT_W-1:0] ONE     = CNT_W'(1);

   sste_pkg::state_type state_ff, state_in;

   logic [CNT_W-1:0]                   i_ff, i_in;
   logic [CNT_W-1:0]                   j_ff, j_in;
   logic [CNT_W-1:0]                   a_count_ff, a_count_in;
   logic [CNT_W-1:0]                   b_count_ff, b_count_in;
   logic signed [sste_pkg::DATA_W-1:0] value_ff, value_in;
   logic                               pend_valid_ff, pend_valid_in;
   logic signed [sste_pkg::DATA_W-1:0] pend_elem_ff, pend_elem_in;
   logic                               out_strobe_ff, out_strobe_in;
   logic [sste_pkg::STATUS_W-1:0]      out_status_ff, out_status_in;
   logic signed [sste_pkg::DATA_W-1:0] out_elem_ff, out_elem_in;
   logic                               out_last_ff, out_last_in;

   // per-cycle requests into the result stage
   logic                               push;
   logic signed [sste_pkg::DATA_W-1:0] push_data;
   logic                               finish;
   logic                               single;
   logic [sste_pkg::STATUS_W-1:0]      single_status;

   logic a_done;
   logic b_done;

   assign a_done = (i_ff >= a_count_ff);
   assign b_done = (j_ff >= b_count_ff);

   // state and counter registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= sste_pkg::ST_IDLE;
         i_ff          <= '0;
         j_ff          <= '0;
         a_count_ff    <= '0;
         b_count_ff    <= '0;
         pend_valid_ff <= 1'b0;
         out_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         i_ff          <= i_in;
         j_ff          <= j_in;
         a_count_ff    <= a_count_in;
         b_count_ff    <= b_count_in;
         pend_valid_ff <= pend_valid_in;
         out_strobe_ff <= out_strobe_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      value_ff      <= value_in;
      pend_elem_ff  <= pend_elem_in;
      out_status_ff <= out_status_in;
      out_elem_ff   <= out_elem_in;
      out_last_ff   <= out_last_in;
   end

   // next state and datapath control
   always_comb begin
      state_in      = state_ff;
      i_in          = i_ff;
      j_in          = j_ff;
      a_count_in    = a_count_ff;
      b_count_in    = b_count_ff;
      value_in      = value_ff;
      push          = 1'b0;
      push_data     = stat.a_rd_data;
      finish        = 1'b0;
      single        = 1'b0;
      single_status = sste_pkg::STAT_EMPTY;

      ctl               = '0;
      ctl.a_rd_idx      = i_ff;
      ctl.b_rd_idx      = j_ff;
      ctl.cmp_value     = value_ff;
      ctl.a_wr_idx      = a_count_ff;
      ctl.b_wr_idx      = b_count_ff;
      ctl.a_wr_data     = req_value;
      ctl.b_wr_data     = req_value;

      busy = (state_ff != sste_pkg::ST_IDLE);

      unique case (state_ff)
         sste_pkg::ST_IDLE: begin
            if (start) begin
               value_in = req_value;
               i_in     = '0;
               j_in     = '0;
               unique case (req_kind)
                  sste_pkg::KIND_APPEND_A: begin
                     single = 1'b1;
                     if (a_count_ff >= CAP_CNT) begin
                        single_status = sste_pkg::STAT_FULL;
                     end else begin
                        single_status = sste_pkg::STAT_APPENDED;
                        ctl.a_wr_en   = 1'b1;
                        a_count_in    = a_count_ff + ONE;
                     end
                  end
                  sste_pkg::KIND_APPEND_B: begin
                     single = 1'b1;
                     if (b_count_ff >= CAP_CNT) begin
                        single_status = sste_pkg::STAT_FULL;
                     end else begin
                        single_status = sste_pkg::STAT_APPENDED;
                        ctl.b_wr_en   = 1'b1;
                        b_count_in    = b_count_ff + ONE;
                     end
                  end
                  sste_pkg::KIND_SEARCH: state_in = sste_pkg::ST_SEARCH;
                  sste_pkg::KIND_REMOVE: state_in = sste_pkg::ST_REMOVE;
                  sste_pkg::KIND_ISECT:  state_in = sste_pkg::ST_ISECT;
                  sste_pkg::KIND_UNION:  state_in = sste_pkg::ST_UNION;
                  default: ;
               endcase
            end
         end

         // walk A against the command value
         sste_pkg::ST_SEARCH: begin
            ctl.cmp_use_value = 1'b1;
            if (a_done) begin
               single        = 1'b1;
               single_status = sste_pkg::STAT_ABSENT;
               state_in      = sste_pkg::ST_IDLE;
            end else if (stat.eq) begin
               single        = 1'b1;
               single_status = sste_pkg::STAT_FOUND;
               state_in      = sste_pkg::ST_IDLE;
            end else begin
               i_in = i_ff + ONE;
            end
         end

         sste_pkg::ST_REMOVE: begin
            ctl.cmp_use_value = 1'b1;
            if (a_done) begin
               single        = 1'b1;
               single_status = sste_pkg::STAT_NOT_REMOVED;
               state_in      = sste_pkg::ST_IDLE;
            end else if (stat.eq) begin
               state_in = sste_pkg::ST_SHIFT;
            end else begin
               i_in = i_ff + ONE;
            end
         end

         // close the gap: A[i] <= A[i+1], one entry a cycle
         sste_pkg::ST_SHIFT: begin
            ctl.a_rd_idx = i_ff + ONE;
            if ((i_ff + ONE) < a_count_ff) begin
               ctl.a_wr_en   = 1'b1;
               ctl.a_wr_idx  = i_ff;
               ctl.a_wr_data = stat.a_rd_data;
               i_in          = i_ff + ONE;
            end else begin
               a_count_in    = a_count_ff - ONE;
               single        = 1'b1;
               single_status = sste_pkg::STAT_REMOVED;
               state_in      = sste_pkg::ST_IDLE;
            end
         end

         // every A entry against every B entry, A order
         sste_pkg::ST_ISECT: begin
            if (a_done) begin
               finish   = 1'b1;
               state_in = sste_pkg::ST_IDLE;
            end else if (b_done) begin
               i_in = i_ff + ONE;
               j_in = '0;
            end else begin
               push      = stat.eq;
               push_data = stat.a_rd_data;
               j_in      = j_ff + ONE;
            end
         end

         // merge; equal heads emit once and both advance
         sste_pkg::ST_UNION: begin
            if (a_done && b_done) begin
               finish   = 1'b1;
               state_in = sste_pkg::ST_IDLE;
            end else if (a_done) begin
               push      = 1'b1;
               push_data = stat.b_rd_data;
               j_in      = j_ff + ONE;
            end else if (b_done) begin
               push      = 1'b1;
               push_data = stat.a_rd_data;
               i_in      = i_ff + ONE;
            end else if (stat.eq) begin
               push      = 1'b1;
               push_data = stat.a_rd_data;
               i_in      = i_ff + ONE;
               j_in      = j_ff + ONE;
            end else if (stat.gt) begin
               push      = 1'b1;
               push_data = stat.b_rd_data;
               j_in      = j_ff + ONE;
            end else begin
               push      = 1'b1;
               push_data = stat.a_rd_data;
               i_in      = i_ff + ONE;
            end
         end

         default: state_in = sste_pkg::ST_IDLE;
      endcase
   end

   // result stage: one element is held back so the final one can carry last
   always_comb begin
      pend_valid_in = pend_valid_ff;
      pend_elem_in  = pend_elem_ff;
      out_strobe_in = 1'b0;
      out_status_in = single_status;
      out_elem_in   = '0;
      out_last_in   = 1'b1;

      if ((state_ff == sste_pkg::ST_IDLE) && start) begin
         pend_valid_in = 1'b0;
      end

      if (single) begin
         out_strobe_in = 1'b1;
      end else if (push) begin
         pend_valid_in = 1'b1;
         pend_elem_in  = push_data;
         if (pend_valid_ff) begin
            out_strobe_in = 1'b1;
            out_status_in = sste_pkg::STAT_ELEMENT;
            out_elem_in   = pend_elem_ff;
            out_last_in   = 1'b0;
         end
      end else if (finish) begin
         out_strobe_in = 1'b1;
         pend_valid_in = 1'b0;
         if (pend_valid_ff) begin
            out_status_in = sste_pkg::STAT_ELEMENT;
            out_elem_in   = pend_elem_ff;
         end else begin
            out_status_in = sste_pkg::STAT_EMPTY;
         end
      end
   end

   assign rsp_strobe  = out_strobe_ff;
   assign rsp_status  = out_status_ff;
   assign rsp_element = out_elem_ff;
   assign rsp_last    = out_last_ff;

endmodule

/* rtl/small_set_table_engine.sv */
// Top level: set storage, read selection, shared compare unit and sequencer.
//
//   channel   ports                                    transfer
//   command   start, busy, req_kind, req_value         start high while busy low
//   result    rsp_strobe, rsp_status, rsp_element,     every cycle rsp_strobe is high
//             rsp_last
//
// Append and kinds 6/7 finish in the command cycle; busy stays low.
// Search and remove scan A one entry a cycle, and remove then moves each later entry down
// one place a cycle.
// Intersection and union run on the single compare unit, which sees one A entry and one B
// entry per cycle.
// A single result leaves the cycle after the deciding cycle; an element leaves the cycle
// after the next element is found or the list ends. The receiver cannot stall.
// Synchronous reset empties both sets.
module small_set_table_engine #(
   parameter int SET_CAPACITY = 8
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic [sste_pkg::KIND_W-1:0]        req_kind,
   input  logic signed [sste_pkg::DATA_W-1:0] req_value,
   output logic                               rsp_strobe,
   output logic [sste_pkg::STATUS_W-1:0]      rsp_status,
   output logic signed [sste_pkg::DATA_W-1:0] rsp_element,
   output logic                               rsp_last
);

   localparam int CNT_W = sste_pkg::CNT_W;

   logic signed [sste_pkg::DATA_W-1:0] a_mem_ff [SET_CAPACITY];
   logic signed [sste_pkg::DATA_W-1:0] b_mem_ff [SET_CAPACITY];

   sste_pkg::ctl_type  ctl;
   sste_pkg::stat_type stat;

   logic signed [sste_pkg::DATA_W-1:0] a_rd;
   logic signed [sste_pkg::DATA_W-1:0] b_rd;
   logic signed [sste_pkg::DATA_W-1:0] cmp_rhs;
   logic                               cmp_eq;
   logic                               cmp_gt;

   // set storage, one write port each
   always_ff @(posedge clock) begin
      for (int k = 0; k < SET_CAPACITY; k++) begin
         if (ctl.a_wr_en && (ctl.a_wr_idx == CNT_W'(k))) begin
            a_mem_ff[k] <= ctl.a_wr_data;
         end
         if (ctl.b_wr_en && (ctl.b_wr_idx == CNT_W'(k))) begin
            b_mem_ff[k] <= ctl.b_wr_data;
         end
      end
   end

   // one read port per set
   always_comb begin
      a_rd = '0;
      b_rd = '0;
      for (int k = 0; k < SET_CAPACITY; k++) begin
         if (ctl.a_rd_idx == CNT_W'(k)) begin
            a_rd = a_mem_ff[k];
         end
         if (ctl.b_rd_idx == CNT_W'(k)) begin
            b_rd = b_mem_ff[k];
         end
      end
   end

   // compare A entry against command value or B entry
   assign cmp_rhs = ctl.cmp_use_value ? ctl.cmp_value : b_rd;

   sste_cmp u_cmp (
      .lhs (a_rd),
      .rhs (cmp_rhs),
      .eq  (cmp_eq),
      .gt  (cmp_gt)
   );

   always_comb begin
      stat.a_rd_data = a_rd;
      stat.b_rd_data = b_rd;
      stat.eq        = cmp_eq;
      stat.gt        = cmp_gt;
   end

   sste_ctrl #(
      .SET_CAPACITY (SET_CAPACITY)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_kind    (req_kind),
      .req_value   (req_value),
      .stat        (stat),
      .ctl         (ctl),
      .rsp_strobe  (rsp_strobe),
      .rsp_status  (rsp_status),
      .rsp_element (rsp_element),
      .rsp_last    (rsp_last)
   );

endmodule

/* tb/sv/tb.sv */
// Testbench for small_set_table_engine: set predictor, result scoreboard and command drivers.
module tb;

   localparam int KIND_W   = sste_pkg::KIND_W;
   localparam int DATA_W   = sste_pkg::DATA_W;
   localparam int STATUS_W = sste_pkg::STATUS_W;

   localparam int SET_CAPACITY    = 8;
   localparam int RANDOM_COMMANDS = 400;
   localparam int QUIET_TAIL      = 60;
   localparam int TAIL_CYCLES     = 200;
   localparam int CYCLE_LIMIT     = 400000;

   // kinds the block ignores
   localparam logic [KIND_W-1:0] KIND_RSVD_6 = 3'd6;
   localparam logic [KIND_W-1:0] KIND_RSVD_7 = 3'd7;

   localparam logic signed [DATA_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [DATA_W-1:0] VAL_MIN = 32'sh8000_0000;

   typedef struct {
      logic [STATUS_W-1:0]      status;
      logic signed [DATA_W-1:0] element;
      logic                     last;
   } set_result_type;

   // Shadow copy of both sets plus the queue of results still owed by the block.
   class set_scoreboard;
      logic signed [DATA_W-1:0] a_entries[SET_CAPACITY];
      logic signed [DATA_W-1:0] b_entries[SET_CAPACITY];
      int                       a_count;
      int                       b_count;
      set_result_type           pending_set_results[$];
      int                       fail_count;

      function new();
         a_count    = 0;
         b_count    = 0;
         fail_count = 0;
      endfunction

      function void add_result(logic [STATUS_W-1:0] status,
                               logic signed [DATA_W-1:0] element, logic last);
         set_result_type res;
         res.status  = status;
         res.element = element;
         res.last    = last;
         pending_set_results.push_back(res);
      endfunction

      // close an element list: empty marker, or flag the final element
      function void close_list(int n);
         set_result_type res;
         if (n == 0) begin
            add_result(sste_pkg::STAT_EMPTY, '0, 1'b1);
         end else begin
            res      = pending_set_results.pop_back();
            res.last = 1'b1;
            pending_set_results.push_back(res);
         end
      endfunction

      // predict the results of one accepted command and update the sets
      function void note_command(logic [KIND_W-1:0] kind,
                                 logic signed [DATA_W-1:0] value);
         int  i;
         int  j;
         int  n;
         int  hit;
         n   = 0;
         hit = -1;
         case (kind)
            sste_pkg::KIND_APPEND_A: begin
               if (a_count >= SET_CAPACITY) begin
                  add_result(sste_pkg::STAT_FULL, '0, 1'b1);
               end else begin
                  a_entries[a_count] = value;
                  a_count++;
                  add_result(sste_pkg::STAT_APPENDED, '0, 1'b1);
               end
            end
            sste_pkg::KIND_APPEND_B: begin
               if (b_count >= SET_CAPACITY) begin
                  add_result(sste_pkg::STAT_FULL, '0, 1'b1);
               end else begin
                  b_entries[b_count] = value;
                  b_count++;
                  add_result(sste_pkg::STAT_APPENDED, '0, 1'b1);
               end
            end
            sste_pkg::KIND_SEARCH: begin
               for (i = 0; i < a_count; i++)
                  if (a_entries[i] == value) hit = i;
               add_result((hit >= 0) ? sste_pkg::STAT_FOUND : sste_pkg::STAT_ABSENT,
                          '0, 1'b1);
            end
            sste_pkg::KIND_REMOVE: begin
               for (i = a_count - 1; i >= 0; i--)
                  if (a_entries[i] == value) hit = i;
               if (hit >= 0) begin
                  // later entries move down one place
                  for (j = hit; j + 1 < a_count; j++)
                     a_entries[j] = a_entries[j + 1];
                  a_count--;
                  add_result(sste_pkg::STAT_REMOVED, '0, 1'b1);
               end else begin
                  add_result(sste_pkg::STAT_NOT_REMOVED, '0, 1'b1);
               end
            end
            sste_pkg::KIND_ISECT: begin
               for (i = 0; i < a_count; i++)
                  for (j = 0; j < b_count; j++)
                     if (a_entries[i] == b_entries[j]) begin
                        add_result(sste_pkg::STAT_ELEMENT, a_entries[i], 1'b0);
                        n++;
                     end
               close_list(n);
            end
            sste_pkg::KIND_UNION: begin
               i = 0;
               j = 0;
               // signed merge in stored order; equal heads emit once
               while (i < a_count || j < b_count) begin
                  if (i >= a_count) begin
                     add_result(sste_pkg::STAT_ELEMENT, b_entries[j], 1'b0);
                     j++;
                  end else if (j >= b_count) begin
                     add_result(sste_pkg::STAT_ELEMENT, a_entries[i], 1'b0);
                     i++;
                  end else if (a_entries[i] == b_entries[j]) begin
                     add_result(sste_pkg::STAT_ELEMENT, a_entries[i], 1'b0);
                     i++;
                     j++;
                  end else if (a_entries[i] > b_entries[j]) begin
                     add_result(sste_pkg::STAT_ELEMENT, b_entries[j], 1'b0);
                     j++;
                  end else begin
                     add_result(sste_pkg::STAT_ELEMENT, a_entries[i], 1'b0);
                     i++;
                  end
                  n++;
               end
               close_list(n);
            end
            default: begin
               // ignored kinds give no result
            end
         endcase
      endfunction

      // compare one result transfer with the oldest expectation
      function void check_result(logic [STATUS_W-1:0] status,
                                 logic signed [DATA_W-1:0] element, logic last);
         set_result_type exp_res;
         if (pending_set_results.size() == 0) begin
            $display("%0t: result expected none actual status %0d element %0d last %0d",
                     $time, status, element, last);
            fail_count++;
         end else begin
            exp_res = pending_set_results.pop_front();
            if (status !== exp_res.status) begin
               $display("%0t: status expected %0d actual %0d",
                        $time, exp_res.status, status);
               fail_count++;
            end
            if (element !== exp_res.element) begin
               $display("%0t: element expected %0d actual %0d",
                        $time, exp_res.element, element);
               fail_count++;
            end
            if (last !== exp_res.last) begin
               $display("%0t: last expected %0d actual %0d",
                        $time, exp_res.last, last);
               fail_count++;
            end
         end
      endfunction
   endclass

   logic                     clock;
   logic                     reset;
   logic                     start;
   logic                     busy;
   logic [KIND_W-1:0]        req_kind;
   logic signed [DATA_W-1:0] req_value;
   logic                     rsp_strobe;
   logic [STATUS_W-1:0]      rsp_status;
   logic signed [DATA_W-1:0] rsp_element;
   logic                     rsp_last;

   set_scoreboard sb = new();

   small_set_table_engine #(
      .SET_CAPACITY (SET_CAPACITY)
   ) i_dut (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_kind    (req_kind),
      .req_value   (req_value),
      .rsp_strobe  (rsp_strobe),
      .rsp_status  (rsp_status),
      .rsp_element (rsp_element),
      .rsp_last    (rsp_last)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // result check and command capture at each rising edge
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_strobe !== 1'b0) sb.check_result(rsp_status, rsp_element, rsp_last);
         if (start && !busy) sb.note_command(req_kind, req_value);
      end
   end

   // run limit
   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // hold one command until the block takes it; start stays high afterwards
   task automatic send_command(input logic [KIND_W-1:0] kind,
                               input logic signed [DATA_W-1:0] value);
      logic taken;
      start     = 1'b1;
      req_kind  = kind;
      req_value = value;
      taken     = 1'b0;
      while (!taken) begin
         @(posedge clock);
         taken = !busy;
         @(negedge clock);
      end
   endtask

   // sender gap with noise on the payload
   task automatic idle_cycles(input int n);
      start     = 1'b0;
      req_kind  = KIND_W'($urandom);
      req_value = $urandom;
      repeat (n) @(negedge clock);
   endtask

   // mostly a small pool so values collide, plus extremes and full-range values
   function automatic logic signed [DATA_W-1:0] pick_value();
      int r;
      r = $urandom_range(0, 9);
      if (r < 5) return $urandom_range(0, 6) - 3;
      if (r == 5) begin
         case ($urandom_range(0, 3))
            0:       return VAL_MIN;
            1:       return VAL_MAX;
            2:       return '0;
            default: return '1;
         endcase
      end
      return $urandom;
   endfunction

   // search and remove operands hit current A entries more often than not
   function automatic logic signed [DATA_W-1:0] pick_a_operand();
      if (sb.a_count > 0 && $urandom_range(0, 9) < 6)
         return sb.a_entries[$urandom_range(0, sb.a_count - 1)];
      return pick_value();
   endfunction

   initial begin
      int  n_cmds;
      int  r;
      int  k;
      int  base;
      int  step;
      int  fill;
      logic quiet;

      reset     = 1'b1;
      start     = 1'b0;
      req_kind  = sste_pkg::KIND_APPEND_A;
      req_value = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: empty sets, extremes, signed ordering, first-entry remove, full set
      send_command(sste_pkg::KIND_UNION, 32'sd5);
      send_command(sste_pkg::KIND_ISECT, 32'sd5);
      send_command(sste_pkg::KIND_SEARCH, 32'sd0);
      send_command(sste_pkg::KIND_REMOVE, 32'sd0);
      send_command(sste_pkg::KIND_APPEND_A, VAL_MAX);
      send_command(sste_pkg::KIND_APPEND_A, VAL_MIN);
      send_command(sste_pkg::KIND_UNION, '0);
      send_command(sste_pkg::KIND_ISECT, '0);
      send_command(sste_pkg::KIND_APPEND_B, -32'sd1);
      send_command(sste_pkg::KIND_APPEND_B, VAL_MIN);
      send_command(sste_pkg::KIND_UNION, VAL_MAX);
      send_command(sste_pkg::KIND_ISECT, VAL_MIN);
      send_command(sste_pkg::KIND_SEARCH, VAL_MIN);
      send_command(sste_pkg::KIND_REMOVE, VAL_MAX);
      send_command(sste_pkg::KIND_REMOVE, 32'sd12345);
      send_command(KIND_RSVD_6, VAL_MAX);
      send_command(KIND_RSVD_7, VAL_MIN);
      send_command(sste_pkg::KIND_APPEND_A, -32'sd1);
      send_command(sste_pkg::KIND_APPEND_A, 32'sd3);
      send_command(sste_pkg::KIND_APPEND_A, 32'sd3);
      send_command(sste_pkg::KIND_APPEND_A, VAL_MAX);
      send_command(sste_pkg::KIND_APPEND_A, 32'sd0);
      send_command(sste_pkg::KIND_APPEND_A, 32'sd7);
      send_command(sste_pkg::KIND_APPEND_A, -32'sd1);
      send_command(sste_pkg::KIND_APPEND_A, 32'sd1);
      send_command(sste_pkg::KIND_UNION, '1);
      send_command(sste_pkg::KIND_ISECT, '1);

      // random commands; idle bursts except in every third stretch and the tail
      n_cmds = 0;
      while (n_cmds < RANDOM_COMMANDS) begin
         quiet = (n_cmds >= RANDOM_COMMANDS - QUIET_TAIL) || ((n_cmds / 50) % 3 == 2);
         if (!quiet && $urandom_range(0, 3) == 0) idle_cycles($urandom_range(1, 6));
         r = $urandom_range(0, 99);
         if (r < 4) begin
            // drain A, then refill it in non-descending order so the merge sees sorted data
            while (sb.a_count > 0) begin
               send_command(sste_pkg::KIND_REMOVE,
                            sb.a_entries[$urandom_range(0, sb.a_count - 1)]);
               n_cmds++;
            end
            base = int'($urandom_range(0, 6)) - 3;
            step = $urandom_range(0, 2);
            fill = $urandom_range(1, SET_CAPACITY);
            for (k = 0; k < fill; k++) begin
               send_command(sste_pkg::KIND_APPEND_A, base + k * step);
               n_cmds++;
            end
         end else begin
            if (r < 32)       send_command(sste_pkg::KIND_APPEND_A, pick_value());
            else if (r < 38)  send_command(sste_pkg::KIND_APPEND_B, pick_value());
            else if (r < 50)  send_command(sste_pkg::KIND_SEARCH, pick_a_operand());
            else if (r < 72)  send_command(sste_pkg::KIND_REMOVE, pick_a_operand());
            else if (r < 84)  send_command(sste_pkg::KIND_ISECT, pick_value());
            else if (r < 96)  send_command(sste_pkg::KIND_UNION, pick_value());
            else if (r < 98)  send_command(KIND_RSVD_6, pick_value());
            else              send_command(KIND_RSVD_7, pick_value());
            if (r < 96) n_cmds++;
         end
      end
      start = 1'b0;

      // drain outstanding results, then watch for strays
      while (sb.pending_set_results.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (sb.fail_count == 0 && sb.pending_set_results.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end
endmodule
